// ===== hdl/sof_pkg.sv =====
package sof_pkg;

    // samples seen so far, saturating
    localparam int unsigned COUNT_WIDTH = 3;
    localparam logic [COUNT_WIDTH-1:0] COUNT_SILENT = 3'd3;
    localparam logic [COUNT_WIDTH-1:0] COUNT_FULL   = 3'd4;

    // threshold multiplier, unsigned Q8.8
    localparam int unsigned FACTOR_WIDTH = 16;
    localparam logic [FACTOR_WIDTH-1:0] SPIKE_FACTOR_RESET = 16'd25600;

    // fraction bits of the factor, applied to the jump side of the compare
    localparam int unsigned FACTOR_FRAC = 8;

    localparam int unsigned TIME_WIDTH = 32;

    // how an item in flight is treated
    typedef enum logic {
        KIND_PASS,
        KIND_TEST
    } t_kind;

    // control of one pipeline stage
    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_stage_ctl;

endpackage

// ===== hdl/sof_window.sv =====
module sof_window
    import sof_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic                                i_advance,
    input  logic [TIME_WIDTH-1:0]               i_sample_time,
    input  logic [VALUE_WIDTH-1:0]              i_sample_value,
    output t_stage_ctl                          o_ctl,
    output logic [TIME_WIDTH-1:0]               o_time,
    output logic [3:0][VALUE_WIDTH-1:0]         o_window
);

    logic [3:0][VALUE_WIDTH-1:0] r_win;
    logic [TIME_WIDTH-1:0]       r_held_time;
    logic [TIME_WIDTH-1:0]       r_time;
    logic [COUNT_WIDTH-1:0]      r_count;
    t_stage_ctl                  r_ctl;
    t_stage_ctl                  n_ctl;

    // stage control for the item entering
    always_comb begin
        n_ctl = r_ctl;
        if (i_accept) begin
            n_ctl.valid = (r_count != COUNT_SILENT);
            n_ctl.kind  = (r_count == COUNT_FULL) ? KIND_TEST : KIND_PASS;
        end else if (i_advance) begin
            n_ctl.valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= '{valid: 1'b0, kind: KIND_PASS};
            r_count     <= '0;
            r_win       <= '0;
            r_held_time <= '0;
        end else begin
            r_ctl <= n_ctl;
            if (i_accept) begin
                r_win       <= {i_sample_value, r_win[3], r_win[2], r_win[1]};
                r_held_time <= i_sample_time;
                if (r_count != COUNT_FULL) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // time to emit: new sample when passing, previous one when tested
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_time <= (r_count == COUNT_FULL) ? r_held_time : i_sample_time;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_time   = r_time;
    assign o_window = r_win;

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_FULL)
        else $error("sample count beyond saturation");

    a_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_count == COUNT_SILENT |=> !r_ctl.valid)
        else $error("fourth item entered the pipeline");

    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_win[3] == $past(i_sample_value))
        else $error("window did not take the new sample");

endmodule

// ===== hdl/sof_measure.sv =====
module sof_measure
    import sof_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_load,
    input  logic                                    i_drain,
    input  t_stage_ctl                              i_ctl,
    input  logic [TIME_WIDTH-1:0]                   i_time,
    input  logic [3:0][VALUE_WIDTH-1:0]             i_window,
    input  logic [FACTOR_WIDTH-1:0]                 i_factor,
    output t_stage_ctl                              o_ctl,
    output logic                                    o_flip,
    output logic [VALUE_WIDTH+FACTOR_FRAC:0]        o_scaled,
    output logic [VALUE_WIDTH+FACTOR_WIDTH:0]       o_prod,
    output logic [TIME_WIDTH-1:0]                   o_time,
    output logic [VALUE_WIDTH-1:0]                  o_value
);

    localparam int unsigned DW = VALUE_WIDTH + 1;
    localparam int unsigned SW = VALUE_WIDTH + FACTOR_FRAC + 1;
    localparam int unsigned PW = VALUE_WIDTH + FACTOR_WIDTH + 1;

    logic signed [VALUE_WIDTH-1:0] a, b, c, d;
    logic signed [VALUE_WIDTH-1:0] lo, hi;
    logic [DW-1:0] d1, d2, j1, j2, jump, range;
    logic          d1_pos, d1_neg, d2_pos, d2_neg, flip;

    t_stage_ctl    r_ctl;
    logic          r_flip;
    logic [SW-1:0] r_scaled;
    logic [PW-1:0] r_prod;
    logic [TIME_WIDTH-1:0]  r_time;
    logic [VALUE_WIDTH-1:0] r_value;

    assign a = i_window[0];
    assign b = i_window[1];
    assign c = i_window[2];
    assign d = i_window[3];

    // differences around the middle sample and their signs
    always_comb begin
        d1     = {b[VALUE_WIDTH-1], b} - {c[VALUE_WIDTH-1], c};
        d2     = {c[VALUE_WIDTH-1], c} - {d[VALUE_WIDTH-1], d};
        d1_neg = d1[DW-1];
        d2_neg = d2[DW-1];
        d1_pos = !d1[DW-1] && (|d1);
        d2_pos = !d2[DW-1] && (|d2);
        flip   = (d1_pos && d2_neg) || (d1_neg && d2_pos);
        j1     = d1_neg ? (~d1 + 1'b1) : d1;
        j2     = d2_neg ? (~d2 + 1'b1) : d2;
        jump   = (j1 > j2) ? j1 : j2;
    end

    // range of the three neighbours
    always_comb begin
        lo = a;
        hi = a;
        if (b < lo) lo = b;
        if (d < lo) lo = d;
        if (b > hi) hi = b;
        if (d > hi) hi = d;
        range = {hi[VALUE_WIDTH-1], hi} - {lo[VALUE_WIDTH-1], lo};
    end

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '{valid: 1'b0, kind: KIND_PASS};
        end else if (i_load) begin
            r_ctl <= i_ctl;
        end else if (i_drain) begin
            r_ctl.valid <= 1'b0;
        end
    end

    // threshold product and scaled jump
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_flip   <= flip;
            r_scaled <= {jump, {FACTOR_FRAC{1'b0}}};
            r_prod   <= PW'(range) * PW'(i_factor);
            r_time   <= i_time;
            r_value  <= (i_ctl.kind == KIND_TEST) ? i_window[2] : i_window[3];
        end
    end

    assign o_ctl    = r_ctl;
    assign o_flip   = r_flip;
    assign o_scaled = r_scaled;
    assign o_prod   = r_prod;
    assign o_time   = r_time;
    assign o_value  = r_value;

endmodule

// ===== hdl/sof_emit.sv =====
module sof_emit
    import sof_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic                                i_out_ready,
    input  t_stage_ctl                          i_ctl,
    input  logic                                i_flip,
    input  logic [VALUE_WIDTH+FACTOR_FRAC:0]    i_scaled,
    input  logic [VALUE_WIDTH+FACTOR_WIDTH:0]   i_prod,
    input  logic [TIME_WIDTH-1:0]               i_time,
    input  logic [VALUE_WIDTH-1:0]              i_value,
    output logic                                o_valid,
    output logic [TIME_WIDTH-1:0]               o_time,
    output logic [VALUE_WIDTH-1:0]              o_value
);

    localparam int unsigned PW = VALUE_WIDTH + FACTOR_WIDTH + 1;

    logic keep;
    logic r_valid;
    logic [TIME_WIDTH-1:0]  r_time;
    logic [VALUE_WIDTH-1:0] r_value;

    // spike: sign change and jump above the threshold
    assign keep = (i_ctl.kind == KIND_PASS) || !(i_flip && (PW'(i_scaled) > i_prod));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= keep;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_time  <= i_time;
            r_value <= i_value;
        end
    end

    assign o_valid = r_valid;
    assign o_time  = r_time;
    assign o_value = r_value;

endmodule

// ===== hdl/spike_outlier_filter.sv =====
// an accepted item moves through the window stage, the measure stage and the output register
// throughput: one item per cycle; the output register and two internal stages
// each hold an item, so input stalls only when all three are full
// the fourth item and dropped spikes leave no result
// reset (synchronous, active low) clears window, held time, count, pipeline
// and sets the spike factor to 100.0
module spike_outlier_filter
    import sof_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [FACTOR_WIDTH-1:0]     i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [TIME_WIDTH-1:0]       i_sample_time,
    input  logic [VALUE_WIDTH-1:0]      i_sample_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [TIME_WIDTH-1:0]       o_out_time,
    output logic [VALUE_WIDTH-1:0]      o_out_value
);

    logic [FACTOR_WIDTH-1:0] r_factor;

    t_stage_ctl                         s1_ctl, s2_ctl;
    logic [TIME_WIDTH-1:0]              s1_time, s2_time;
    logic [3:0][VALUE_WIDTH-1:0]        s1_window;
    logic                               s2_flip;
    logic [VALUE_WIDTH+FACTOR_FRAC:0]   s2_scaled;
    logic [VALUE_WIDTH+FACTOR_WIDTH:0]  s2_prod;
    logic [VALUE_WIDTH-1:0]             s2_value;

    logic accept, s1_adv, s2_adv, s2_ready, s3_ready;

    // spike factor register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= SPIKE_FACTOR_RESET;
        end else if (i_cfg_we) begin
            r_factor <= i_cfg_data;
        end
    end

    // ready chain: a stage takes an item when empty or moving on
    assign s3_ready   = !o_out_valid || i_out_ready;
    assign s2_ready   = !s2_ctl.valid || s3_ready;
    assign o_in_ready = !s1_ctl.valid || s2_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign s1_adv     = s1_ctl.valid && s2_ready;
    assign s2_adv     = s2_ctl.valid && s3_ready;

    sof_window #(.VALUE_WIDTH(VALUE_WIDTH)) u_window (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_advance      (s1_adv),
        .i_sample_time  (i_sample_time),
        .i_sample_value (i_sample_value),
        .o_ctl          (s1_ctl),
        .o_time         (s1_time),
        .o_window       (s1_window)
    );

    sof_measure #(.VALUE_WIDTH(VALUE_WIDTH)) u_measure (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s1_adv),
        .i_drain  (s2_adv),
        .i_ctl    (s1_ctl),
        .i_time   (s1_time),
        .i_window (s1_window),
        .i_factor (r_factor),
        .o_ctl    (s2_ctl),
        .o_flip   (s2_flip),
        .o_scaled (s2_scaled),
        .o_prod   (s2_prod),
        .o_time   (s2_time),
        .o_value  (s2_value)
    );

    sof_emit #(.VALUE_WIDTH(VALUE_WIDTH)) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (s2_adv),
        .i_out_ready (i_out_ready),
        .i_ctl       (s2_ctl),
        .i_flip      (s2_flip),
        .i_scaled    (s2_scaled),
        .i_prod      (s2_prod),
        .i_time      (s2_time),
        .i_value     (s2_value),
        .o_valid     (o_out_valid),
        .o_time      (o_out_time),
        .o_value     (o_out_value)
    );

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_ctl.valid && !s2_ready && !accept |=> s1_ctl.valid)
        else $error("stalled item lost in first stage");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> s1_ctl.valid && s2_ctl.valid && o_out_valid)
        else $error("input stalled with room in the pipeline");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_ctl.valid && !s3_ready |=> s2_ctl.valid && $stable(s2_time))
        else $error("stalled item lost in second stage");

endmodule

// ===== tb/sv/spike_outlier_filter_check.sv =====
`timescale 1ns / 100ps

// watches both channels, predicts which samples survive the spike filter
// and compares every emitted item with the oldest prediction
module spike_outlier_filter_check
    import sof_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [FACTOR_WIDTH-1:0] i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [TIME_WIDTH-1:0]   i_sample_time,
    input  logic [VALUE_WIDTH-1:0]  i_sample_value,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [TIME_WIDTH-1:0]   i_out_time,
    input  logic [VALUE_WIDTH-1:0]  i_out_value,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic [TIME_WIDTH-1:0]  stamp;
        logic [VALUE_WIDTH-1:0] value;
    } t_emitted;

    // samples still expected on the output, oldest first
    t_emitted                emitted_q[$];
    t_emitted                want;

    // predictor copy of the filter state
    logic [FACTOR_WIDTH-1:0] factor;
    logic [VALUE_WIDTH-1:0]  window [4];
    logic [TIME_WIDTH-1:0]   held_stamp;
    logic [COUNT_WIDTH-1:0]  seen;

    // true when the middle sample c is an isolated spike between b and d
    function automatic logic drops_middle(
        input logic [VALUE_WIDTH-1:0]  a_raw,
        input logic [VALUE_WIDTH-1:0]  b_raw,
        input logic [VALUE_WIDTH-1:0]  c_raw,
        input logic [VALUE_WIDTH-1:0]  d_raw,
        input logic [FACTOR_WIDTH-1:0] f
    );
        longint     a, b, c, d, d1, d2, lo, hi, j1, j2, jump;
        logic [127:0] scaled_jump, threshold;
        a  = longint'($signed(a_raw));
        b  = longint'($signed(b_raw));
        c  = longint'($signed(c_raw));
        d  = longint'($signed(d_raw));
        d1 = b - c;
        d2 = c - d;
        if (!((d1 > 0 && d2 < 0) || (d1 < 0 && d2 > 0)))
            return 1'b0;
        // range of the three neighbors, the middle one left out
        lo = a;
        hi = a;
        if (b < lo) lo = b;
        if (d < lo) lo = d;
        if (b > hi) hi = b;
        if (d > hi) hi = d;
        j1   = (d1 < 0) ? -d1 : d1;
        j2   = (d2 < 0) ? -d2 : d2;
        jump = (j1 > j2) ? j1 : j2;
        // wide enough that a product past 64 bits simply keeps the sample
        scaled_jump = 128'(jump);
        scaled_jump = scaled_jump << FACTOR_FRAC;
        threshold   = 128'(hi - lo) * 128'(f);
        return scaled_jump > threshold;
    endfunction

    task automatic log_failure(input string what);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t: %s", $realtime, what);
    endtask

    // shift one accepted sample in and queue what it lets out
    task automatic accept_sample(
        input logic [TIME_WIDTH-1:0]  stamp,
        input logic [VALUE_WIDTH-1:0] value
    );
        logic [TIME_WIDTH-1:0] prev_stamp;
        t_emitted              item;
        prev_stamp = held_stamp;
        window[0]  = window[1];
        window[1]  = window[2];
        window[2]  = window[3];
        window[3]  = value;
        held_stamp = stamp;
        if (seen < COUNT_SILENT) begin
            item = '{stamp: stamp, value: value};
            emitted_q.insert(emitted_q.size(), item);
        end else if (seen == COUNT_FULL) begin
            if (!drops_middle(window[0], window[1], window[2], window[3], factor)) begin
                item = '{stamp: prev_stamp, value: window[2]};
                emitted_q.insert(emitted_q.size(), item);
            end
        end
        if (seen < COUNT_FULL)
            seen = seen + 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            factor     = SPIKE_FACTOR_RESET;
            window[0]  = '0;
            window[1]  = '0;
            window[2]  = '0;
            window[3]  = '0;
            held_stamp = '0;
            seen       = '0;
            emitted_q.delete();
        end else begin
            if (i_cfg_we)
                factor = i_cfg_data;
            // output side first: nothing accepted now can leave this same edge
            if (i_out_valid && i_out_ready) begin
                if (emitted_q.size() == 0) begin
                    log_failure($sformatf("unexpected item: time %h value %h",
                        i_out_time, i_out_value));
                end else begin
                    want = emitted_q.pop_front();
                    if (want.stamp !== i_out_time || want.value !== i_out_value)
                        log_failure($sformatf(
                            "mismatch: time exp %h got %h, value exp %h got %h",
                            want.stamp, i_out_time, want.value, i_out_value));
                end
            end
            if (i_in_valid && i_in_ready)
                accept_sample(i_sample_time, i_sample_value);
        end
        o_pending = emitted_q.size();
    end

endmodule

// ===== tb/sv/spike_outlier_filter_tb.sv =====
`timescale 1ns / 100ps

module spike_outlier_filter_tb;
    import sof_pkg::*;

    localparam int unsigned VALUE_WIDTH  = 32;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned PHASE_ITEMS  = 365;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [FACTOR_WIDTH-1:0] i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [TIME_WIDTH-1:0]   i_sample_time = '0;
    logic [VALUE_WIDTH-1:0]  i_sample_value = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [TIME_WIDTH-1:0]   o_out_time;
    logic [VALUE_WIDTH-1:0]  o_out_value;

    int                      fail_count;
    int                      pending;
    int                      sent;
    int                      quiet_cycles;

    // random signal state: a slowly wandering level plus the last value sent
    logic signed [VALUE_WIDTH-1:0] level;
    logic [VALUE_WIDTH-1:0]        last_value;
    logic [TIME_WIDTH-1:0]         stamp;

    spike_outlier_filter #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_time  (i_sample_time),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_time     (o_out_time),
        .o_out_value    (o_out_value)
    );

    spike_outlier_filter_check #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_sample_time  (i_sample_time),
        .i_sample_value (i_sample_value),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_time     (o_out_time),
        .i_out_value    (o_out_value),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #5 i_clk = ~i_clk;

    // stall watchdog: cycles without any item moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off to back the filter up,
    // and a stretch that always takes
    initial begin
        int cyc;
        cyc = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc >= 700 && cyc < 820)
                i_out_ready <= 1'b0;
            else if (cyc >= 1400 && cyc < 1800)
                i_out_ready <= 1'b1;
            else
                i_out_ready <= ($urandom_range(0, 99) >= 15);
        end
    end

    // offer one sample and hold it until taken; returns on a falling edge
    task automatic send_sample(
        input logic [TIME_WIDTH-1:0]  t,
        input logic [VALUE_WIDTH-1:0] v
    );
        while (!(sent >= 1000 && sent < 1300) && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_time  <= t;
        i_sample_value <= v;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    // wait until every predicted item is out and dropped ones have cleared
    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_factor(input logic [FACTOR_WIDTH-1:0] f);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= f;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // mostly a noisy level with spikes and flat runs, some raw noise
    task automatic random_samples(input int count);
        int                            pick;
        logic signed [VALUE_WIDTH-1:0] noise;
        logic [VALUE_WIDTH-1:0]        v;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                noise = $urandom_range(0, 32);
                level = level + noise - 16;
                v = level;
            end else if (pick < 70) begin
                noise = 1 << $urandom_range(2, 30);
                v = ($urandom_range(0, 1) != 0) ? level + noise : level - noise;
            end else if (pick < 82) begin
                v = last_value;
            end else if (pick < 90) begin
                level = $urandom;
                v = level;
            end else begin
                v = $urandom;
            end
            if ($urandom_range(0, 9) == 0)
                stamp = $urandom;
            else
                stamp = stamp + $urandom_range(1, 1000);
            last_value = v;
            send_sample(stamp, v);
        end
    endtask

    initial begin
        level      = '0;
        last_value = '0;
        stamp      = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // start-up: three pass through, the fourth is silent
        send_sample(32'h0000_0000, 32'h0000_0000);
        send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'h0000_0001, 32'h8000_0000);
        send_sample(32'h0000_0002, 32'h0000_0000);
        // flat and zero differences are always kept
        send_sample(32'd3, 32'd0);
        send_sample(32'd4, 32'd0);
        send_sample(32'd5, 32'd100);
        // lone bump over a flat neighbourhood: zero range, dropped
        send_sample(32'd6, 32'd0);
        send_sample(32'd7, 32'd0);
        // full-scale swings: huge range keeps everything
        send_sample(32'd8, 32'h7FFF_FFFF);
        send_sample(32'd9, 32'h8000_0000);
        send_sample(32'd10, 32'h7FFF_FFFF);
        send_sample(32'd11, 32'h8000_0000);
        // positive and negative spikes over a gentle ramp
        send_sample(32'd12, 32'd10);
        send_sample(32'd13, 32'd20);
        send_sample(32'd14, 32'd1000000);
        send_sample(32'd15, 32'd30);
        send_sample(32'd16, 32'd40);
        send_sample(32'd17, -32'sd5000);
        send_sample(32'd18, 32'd50);
        // sign change below the threshold is kept
        send_sample(32'd19, 32'd60);
        send_sample(32'd20, -32'sd100);
        send_sample(32'd21, 32'd70);

        // random phases over a range of factors, extremes included
        random_samples(PHASE_ITEMS);
        set_factor(16'd0);
        random_samples(PHASE_ITEMS);
        set_factor(16'hFFFF);
        random_samples(PHASE_ITEMS);
        set_factor(16'd256);
        random_samples(PHASE_ITEMS);
        set_factor(16'($urandom_range(1, 65534)));
        random_samples(PHASE_ITEMS);

        drain();
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
